@@ sv/sorted_median_of_grades_top_macros.svh @@
// Assertion macros for the sorted median of grades RTL.
`ifndef SORTED_MEDIAN_OF_GRADES_TOP_MACROS_SVH
`define SORTED_MEDIAN_OF_GRADES_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SMG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smg: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SMG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smg: next-cycle check failed");

`endif

@@ sv/smg_pkg.sv @@
// Shared types and constants for the sorted median of grades block.
package smg_pkg;

   localparam int SMG_MAX_COUNT = 64;
   localparam int GRADE_W       = 9;
   localparam int POS_W         = 7;
   localparam int MED_W         = 10;
   localparam logic [GRADE_W-1:0] GRADE_TOP = 9'd500;

   // controller states
   typedef enum logic [3:0] {
      S_LOAD,
      S_START,
      S_RDI,
      S_INIT,
      S_SCAN,
      S_SWAP,
      S_SWAP2,
      S_MED0,
      S_MED1,
      S_MED2,
      S_EMIT_LD,
      S_EMIT_WAIT
   } ctrl_state_type;

   // read address selection for the grade store
   typedef enum logic [2:0] {
      RD_I,
      RD_FIRST,
      RD_SCAN_NEXT,
      RD_HALF,
      RD_HALF_M1,
      RD_K,
      RD_K_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       load_en;
      rd_sel_type rd_sel;
      logic       init_pass;
      logic       scan_step;
      logic       wr_pick;
      logic       wr_low;
      logic       cap_med_a;
      logic       cap_med;
      logic       emit_load;
      logic       emit_next;
      logic       run_clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic n_ge2;
      logic scan_more;
      logic pass_more;
      logic emit_last;
      logic rsp_taken;
   } dp_status_type;

endpackage

@@ sv/smg_ctrl.sv @@
// Sequencer for load, selection sort, median and result emission.
module smg_ctrl
   import smg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_final_item,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_valid && req_final_item) state_in = S_START;
         end
         S_START: begin
            state_in = status.n_ge2 ? S_RDI : S_MED0;
         end
         S_RDI:   state_in = S_INIT;
         S_INIT:  state_in = S_SCAN;
         S_SCAN: begin
            if (!status.scan_more) state_in = S_SWAP;
         end
         S_SWAP:  state_in = S_SWAP2;
         S_SWAP2: begin
            state_in = status.pass_more ? S_RDI : S_MED0;
         end
         S_MED0:  state_in = S_MED1;
         S_MED1:  state_in = S_MED2;
         S_MED2:  state_in = S_EMIT_LD;
         S_EMIT_LD: state_in = S_EMIT_WAIT;
         S_EMIT_WAIT: begin
            if (status.rsp_taken) state_in = status.emit_last ? S_LOAD : S_EMIT_LD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      cmd.rd_sel = RD_I;
      req_stall = 1'b1;
      case (state_ff)
         S_LOAD: begin
            req_stall   = 1'b0;
            cmd.load_en = req_valid;
         end
         S_RDI: cmd.rd_sel = RD_I;
         S_INIT: begin
            cmd.init_pass = 1'b1;
            cmd.rd_sel    = RD_FIRST;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.rd_sel    = RD_SCAN_NEXT;
         end
         S_SWAP:  cmd.wr_pick = 1'b1;
         S_SWAP2: cmd.wr_low  = 1'b1;
         S_MED0:  cmd.rd_sel  = RD_HALF;
         S_MED1: begin
            cmd.cap_med_a = 1'b1;
            cmd.rd_sel    = RD_HALF_M1;
         end
         S_MED2: begin
            cmd.cap_med = 1'b1;
            cmd.rd_sel  = RD_K;
         end
         S_EMIT_LD: cmd.emit_load = 1'b1;
         S_EMIT_WAIT: begin
            cmd.rd_sel = RD_K_NEXT;
            if (status.rsp_taken) begin
               cmd.run_clear = status.emit_last;
               cmd.emit_next = !status.emit_last;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ sv/smg_datapath.sv @@
// Grade store, sort registers, median and result word registers.
module smg_datapath
   import smg_pkg::*;
#(
   parameter int MAX_COUNT = SMG_MAX_COUNT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic [GRADE_W-1:0]  req_grade,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [POS_W-1:0]    rsp_position,
   output logic [GRADE_W-1:0]  rsp_sorted_grade,
   output logic [MED_W-1:0]    rsp_median_doubled,
   output logic                rsp_end_of_list,
   output logic                rsp_grades_dropped
);

`include "sorted_median_of_grades_top_macros.svh"

   localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
   localparam int CW = $clog2(MAX_COUNT + 1);
   localparam int XW = CW + 1;

   logic [GRADE_W-1:0] grade_store_ff [MAX_COUNT];
   logic [GRADE_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [GRADE_W-1:0] wr_data;

   logic [CW-1:0]      count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      pick_ff, pick_in;
   logic [GRADE_W-1:0] low_ff, low_in;
   logic [GRADE_W-1:0] ival_ff, ival_in;
   logic [GRADE_W-1:0] med_a_ff, med_a_in;
   logic [MED_W-1:0]   med_ff, med_in;
   logic [AW-1:0]      k_ff, k_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [GRADE_W-1:0] rsp_sorted_grade_ff, rsp_sorted_grade_in;
   logic [MED_W-1:0]   rsp_median_doubled_ff, rsp_median_doubled_in;
   logic               rsp_end_of_list_ff, rsp_end_of_list_in;
   logic               rsp_grades_dropped_ff, rsp_grades_dropped_in;

   logic [GRADE_W-1:0] grade_sat;
   logic [CW-1:0]      half;
   logic [CW-1:0]      k_plus1;
   logic               rsp_taken;

   assign grade_sat = (req_grade > GRADE_TOP) ? GRADE_TOP : req_grade;
   assign half      = count_ff >> 1;
   assign k_plus1   = CW'(k_ff) + CW'(1);
   assign rsp_taken = rsp_valid_ff && !rsp_stall;

   // status back to the sequencer
   always_comb begin
      status.n_ge2     = XW'(count_ff) > XW'(1);
      status.scan_more = (XW'(scan_ff) + XW'(1)) < XW'(count_ff);
      status.pass_more = (XW'(i_ff) + XW'(2)) < XW'(count_ff);
      status.emit_last = (k_plus1 == count_ff);
      status.rsp_taken = rsp_taken;
   end

   // store read address
   always_comb begin
      case (cmd.rd_sel)
         RD_I:         rd_addr = i_ff;
         RD_FIRST:     rd_addr = i_ff + AW'(1);
         RD_SCAN_NEXT: rd_addr = scan_ff + AW'(1);
         RD_HALF:      rd_addr = AW'(half);
         RD_HALF_M1:   rd_addr = AW'(half) - AW'(1);
         RD_K:         rd_addr = k_ff;
         RD_K_NEXT:    rd_addr = k_ff + AW'(1);
         default:      rd_addr = i_ff;
      endcase
   end

   // store write port: load, then the two halves of a swap
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(count_ff);
      wr_data = grade_sat;
      if (cmd.load_en && (count_ff < CW'(MAX_COUNT))) begin
         wr_en = 1'b1;
      end else if (cmd.wr_pick) begin
         wr_en   = 1'b1;
         wr_addr = pick_ff;
         wr_data = ival_ff;
      end else if (cmd.wr_low) begin
         wr_en   = 1'b1;
         wr_addr = i_ff;
         wr_data = low_ff;
      end
   end

   // grade store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) grade_store_ff[wr_addr] <= wr_data;
      rd_data_ff <= grade_store_ff[rd_addr];
   end

   // next values of the working registers
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      i_in        = i_ff;
      scan_in     = scan_ff;
      pick_in     = pick_ff;
      low_in      = low_ff;
      ival_in     = ival_ff;
      med_a_in    = med_a_ff;
      med_in      = med_ff;
      k_in        = k_ff;

      if (cmd.load_en) begin
         if (count_ff < CW'(MAX_COUNT)) count_in = count_ff + CW'(1);
         else                           overflow_in = 1'b1;
      end
      // pass start: current minimum is store[i]
      if (cmd.init_pass) begin
         low_in  = rd_data_ff;
         ival_in = rd_data_ff;
         pick_in = i_ff;
         scan_in = i_ff + AW'(1);
      end
      // data holds store[scan]
      if (cmd.scan_step) begin
         if (rd_data_ff < low_ff) begin
            low_in  = rd_data_ff;
            pick_in = scan_ff;
         end
         scan_in = scan_ff + AW'(1);
      end
      if (cmd.wr_low) i_in = i_ff + AW'(1);
      if (cmd.cap_med_a) med_a_in = rd_data_ff;
      // even count sums the middle pair, odd doubles the middle
      if (cmd.cap_med) begin
         if (!count_ff[0]) med_in = {1'b0, med_a_ff} + {1'b0, rd_data_ff};
         else              med_in = {med_a_ff, 1'b0};
      end
      if (cmd.emit_next) k_in = k_ff + AW'(1);
      if (cmd.run_clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
         i_in        = '0;
         k_in        = '0;
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in          = rsp_valid_ff;
      rsp_position_in       = rsp_position_ff;
      rsp_sorted_grade_in   = rsp_sorted_grade_ff;
      rsp_median_doubled_in = rsp_median_doubled_ff;
      rsp_end_of_list_in    = rsp_end_of_list_ff;
      rsp_grades_dropped_in = rsp_grades_dropped_ff;
      if (rsp_taken) rsp_valid_in = 1'b0;
      if (cmd.emit_load) begin
         rsp_valid_in          = 1'b1;
         rsp_position_in       = POS_W'(k_plus1);
         rsp_sorted_grade_in   = rd_data_ff;
         rsp_median_doubled_in = med_ff;
         rsp_end_of_list_in    = status.emit_last;
         rsp_grades_dropped_in = overflow_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         i_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff               <= scan_in;
      pick_ff               <= pick_in;
      low_ff                <= low_in;
      ival_ff               <= ival_in;
      med_a_ff              <= med_a_in;
      med_ff                <= med_in;
      rsp_position_ff       <= rsp_position_in;
      rsp_sorted_grade_ff   <= rsp_sorted_grade_in;
      rsp_median_doubled_ff <= rsp_median_doubled_in;
      rsp_end_of_list_ff    <= rsp_end_of_list_in;
      rsp_grades_dropped_ff <= rsp_grades_dropped_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_sorted_grade   = rsp_sorted_grade_ff;
   assign rsp_median_doubled = rsp_median_doubled_ff;
   assign rsp_end_of_list    = rsp_end_of_list_ff;
   assign rsp_grades_dropped = rsp_grades_dropped_ff;

   // fill count never passes capacity
   `SMG_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CW'(MAX_COUNT))
   // results leave in ascending order
   `SMG_ASSERT_NOW(a_sorted_order, cmd.emit_load && (k_ff != '0), rd_data_ff >= rsp_sorted_grade_ff)
   // the last word of a run empties the store for the next run
   `SMG_ASSERT_NEXT(a_run_clear, rsp_taken && rsp_end_of_list_ff, (count_ff == '0) && !overflow_ff)

endmodule

@@ sv/sorted_median_of_grades_top.sv @@
// Top level of the sorted median of grades block.
// Grades load one word per cycle into a MAX_COUNT-entry store; grades past
// capacity are dropped and flagged. The word marked final is taken too, then
// the input stalls while the store is sorted by selection sort over its single
// read port and the median is found. Each sorted grade then leaves as one
// result word, the next only once the one before is taken. Input is taken
// again once the last word is gone.
module sorted_median_of_grades_top
   import smg_pkg::*;
#(
   parameter int MAX_COUNT = SMG_MAX_COUNT
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [GRADE_W-1:0]  req_grade,
   input  logic                req_final_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [POS_W-1:0]    rsp_position,
   output logic [GRADE_W-1:0]  rsp_sorted_grade,
   output logic [MED_W-1:0]    rsp_median_doubled,
   output logic                rsp_end_of_list,
   output logic                rsp_grades_dropped
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   smg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_final_item (req_final_item),
      .req_stall      (req_stall),
      .status         (status),
      .cmd            (cmd)
   );

   smg_datapath #(
      .MAX_COUNT (MAX_COUNT)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_grade          (req_grade),
      .cmd                (cmd),
      .status             (status),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_position       (rsp_position),
      .rsp_sorted_grade   (rsp_sorted_grade),
      .rsp_median_doubled (rsp_median_doubled),
      .rsp_end_of_list    (rsp_end_of_list),
      .rsp_grades_dropped (rsp_grades_dropped)
   );

endmodule
